// File: rtl/otdv_pkg.sv
// Shared widths and constants for the orbit transfer delta-v pipeline.
// No dependencies.
package otdv_pkg;

  localparam int unsigned ROOT_W = 32;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned PI_W   = 31;
  // pi in Q29
  localparam logic [PI_W-1:0] PI_Q29 = 31'd1686629713;

endpackage

// File: rtl/otdv_delay.sv
// Enable-gated delay line used to align operands between pipeline units.
// No dependencies.
module otdv_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] dly_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign q_o = dly_q[N-1];

endmodule

// File: rtl/otdv_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on otdv_pkg.
module otdv_sqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [otdv_pkg::RAD_W-1:0]  rad_i,
  output logic [otdv_pkg::ROOT_W-1:0] root_o
);
  import otdv_pkg::*;

  logic [RAD_W-1:0]  xs_q  [ROOT_W+1];
  logic [ROOT_W+1:0] rem_q [ROOT_W+1];
  logic [ROOT_W-1:0] rt_q  [ROOT_W+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0]  <= rad_i;
      rem_q[0] <= '0;
      rt_q[0]  <= '0;
    end
  end

  for (genvar s = 1; s <= ROOT_W; s++) begin : g_stage
    logic [ROOT_W+1:0] rv;
    logic [ROOT_W+1:0] tr;
    logic              ge;

    assign rv = {rem_q[s-1][ROOT_W-1:0], xs_q[s-1][RAD_W-1 -: 2]};
    assign tr = {rt_q[s-1], 2'b01};
    assign ge = (rv >= tr);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xs_q[s]  <= xs_q[s-1] << 2;
        rem_q[s] <= ge ? (rv - tr) : rv;
        rt_q[s]  <= {rt_q[s-1][ROOT_W-2:0], ge};
      end
    end
  end

  assign root_o = rt_q[ROOT_W];

endmodule

// File: rtl/otdv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Flags overflow when the quotient does not fit in Q bits. Depends on otdv_pkg.
module otdv_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned Q  = 32
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [otdv_pkg::RAD_W-1:0] dvd_i,
  input  logic [DW-1:0]             dvs_i,
  output logic [Q-1:0]              quo_o,
  output logic                      ovf_o
);
  import otdv_pkg::*;

  logic [DW-1:0] rem_q [Q+1];
  logic [Q-1:0]  low_q [Q+1];
  logic [DW-1:0] dvs_q [Q+1];
  logic [Q-1:0]  quo_q [Q+1];
  logic [Q:0]    ovf_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(dvd_i >> Q);
      low_q[0] <= dvd_i[Q-1:0];
      dvs_q[0] <= dvs_i;
      quo_q[0] <= '0;
      ovf_q[0] <= ((dvd_i >> Q) >= RAD_W'(dvs_i));
    end
  end

  for (genvar s = 1; s <= Q; s++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rem_q[s-1], low_q[s-1][Q-1]};
    assign ge    = (trial >= {1'b0, dvs_q[s-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DW'(trial - {1'b0, dvs_q[s-1]}) : trial[DW-1:0];
        low_q[s] <= low_q[s-1] << 1;
        dvs_q[s] <= dvs_q[s-1];
        quo_q[s] <= {quo_q[s-1][Q-2:0], ge};
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[Q];
  assign ovf_o = ovf_q[Q];

endmodule

// File: rtl/orbit_transfer_delta_v.sv
// Hohmann transfer delta-v and transfer time, fully pipelined top level.
// Depends on otdv_pkg, otdv_sqrt, otdv_div, otdv_delay.
// Throughput: one beat per cycle while the output is not stalled.
// The whole pipeline advances when the output register is empty or being taken,
// so a stall on the output freezes every stage.
// Reset clears valid bits and loads the register reset values; payload is not reset.
module orbit_transfer_delta_v #(
  parameter int unsigned ALT_FRAC_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] start_altitude_i,
  input  logic signed [31:0] target_altitude_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] burn_one_o,
  output logic signed [31:0] burn_two_o,
  output logic signed [31:0] burn_sum_o,
  output logic [31:0]        travel_time_o,
  output logic [31:0]        axis_length_o,
  output logic               bad_altitude_o
);
  import otdv_pkg::*;

  localparam int unsigned RootShift = 30 + (ALT_FRAC_BITS % 2);
  localparam int unsigned RootHalf  = (ALT_FRAC_BITS + RootShift) / 2;
  localparam int unsigned HpShift   = 9 + ALT_FRAC_BITS + RootHalf;
  localparam int unsigned Lat       = 71;
  localparam logic        RegBody   = 1'b0;
  localparam logic        RegSgp    = 1'b1;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh07FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < 36'shF80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration
  logic [30:0] br_q;
  logic [31:0] sgp_q;
  logic        cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSgp) ? sgp_q : {1'b0, br_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_q  <= 31'd6531212;
      sgp_q <= 32'd41376022;
    end else if (cfg_wr) begin
      if (paddr[2] == RegBody) begin
        br_q <= pwdata[30:0];
      end else begin
        sgp_q <= pwdata;
      end
    end
  end

  // pipeline control
  logic           en;
  logic [Lat-1:0] vld_q;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // radii
  logic        bad_q;
  logic [31:0] r1_q, r2_q;
  logic [32:0] sum_q;
  logic [31:0] a1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bad_q <= (start_altitude_i == 32'sd0) | start_altitude_i[31] |
               (target_altitude_i == 32'sd0) | target_altitude_i[31];
      r1_q  <= 32'(start_altitude_i) + 32'(br_q);
      r2_q  <= 32'(target_altitude_i) + 32'(br_q);
      sum_q <= 33'(start_altitude_i) + 33'(target_altitude_i) + 33'(br_q) + 33'(br_q);
    end
  end

  assign a1 = sum_q[32:1];

  // radius roots and speed ratios
  logic [ROOT_W-1:0] sq1, sq2, sqa;
  logic [30:0]       rat1_raw, rat2_raw, rat1_34, rat2_34;
  logic              rat1_ovf, rat2_ovf;
  logic [31:0]       a34, a70;
  logic              bad70;

  otdv_sqrt u_sq1 (.clk_i, .en_i(en), .rad_i(RAD_W'(r1_q) << RootShift), .root_o(sq1));
  otdv_sqrt u_sq2 (.clk_i, .en_i(en), .rad_i(RAD_W'(r2_q) << RootShift), .root_o(sq2));
  otdv_sqrt u_sqa (.clk_i, .en_i(en), .rad_i(RAD_W'(a1) << RootShift), .root_o(sqa));

  otdv_div #(.DW(33), .Q(31)) u_rat1 (
    .clk_i, .en_i(en), .dvd_i(RAD_W'(r2_q) << 31), .dvs_i(sum_q),
    .quo_o(rat1_raw), .ovf_o(rat1_ovf)
  );
  otdv_div #(.DW(33), .Q(31)) u_rat2 (
    .clk_i, .en_i(en), .dvd_i(RAD_W'(r1_q) << 31), .dvs_i(sum_q),
    .quo_o(rat2_raw), .ovf_o(rat2_ovf)
  );

  otdv_delay #(.W(62), .N(1)) u_dly_rat (
    .clk_i, .en_i(en),
    .d_i({rat1_raw | {31{rat1_ovf}}, rat2_raw | {31{rat2_ovf}}}),
    .q_o({rat1_34, rat2_34})
  );
  otdv_delay #(.W(32), .N(33)) u_dly_a34 (.clk_i, .en_i(en), .d_i(a1), .q_o(a34));
  otdv_delay #(.W(33), .N(69)) u_dly_a70 (
    .clk_i, .en_i(en), .d_i({bad_q, a1}), .q_o({bad70, a70})
  );

  // circular speeds and transfer factors
  logic [32:0]       vc1_raw, vc2_raw, vc1c, vc2c;
  logic              vc1_ovf, vc2_ovf;
  logic [ROOT_W-1:0] sf1_raw, sf2_raw, sf1_68, sf2_68;

  otdv_div #(.DW(32), .Q(33)) u_vc1 (
    .clk_i, .en_i(en), .dvd_i(RAD_W'(sgp_q) << RootHalf), .dvs_i(sq1),
    .quo_o(vc1_raw), .ovf_o(vc1_ovf)
  );
  otdv_div #(.DW(32), .Q(33)) u_vc2 (
    .clk_i, .en_i(en), .dvd_i(RAD_W'(sgp_q) << RootHalf), .dvs_i(sq2),
    .quo_o(vc2_raw), .ovf_o(vc2_ovf)
  );

  otdv_sqrt u_sf1 (.clk_i, .en_i(en), .rad_i(RAD_W'(rat1_34) << 30), .root_o(sf1_raw));
  otdv_sqrt u_sf2 (.clk_i, .en_i(en), .rad_i(RAD_W'(rat2_34) << 30), .root_o(sf2_raw));

  otdv_delay #(.W(2*ROOT_W), .N(1)) u_dly_sf (
    .clk_i, .en_i(en), .d_i({sf1_raw, sf2_raw}), .q_o({sf1_68, sf2_68})
  );

  assign vc1c = vc1_raw | {33{vc1_ovf}};
  assign vc2c = vc2_raw | {33{vc2_ovf}};

  // half period: a * sqrt(a) * pi, then divide by sqrt(mu)
  logic [63:0]          num_q;
  logic [PI_W+31:0]     ph_q, pl_q;
  logic [95:0]          prod, shf;
  logic [RAD_W-1:0]     hp_dvd_q;
  logic [31:0]          hp_raw, tt70;
  logic                 hp_ovf;

  assign prod = (96'(ph_q) << 32) + 96'(pl_q);
  assign shf  = prod >> HpShift;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q    <= 64'(a34) * 64'(sqa);
      ph_q     <= (PI_W+32)'(num_q[63:32]) * (PI_W+32)'(PI_Q29);
      pl_q     <= (PI_W+32)'(num_q[31:0]) * (PI_W+32)'(PI_Q29);
      hp_dvd_q <= (|shf[95:64]) ? '1 : shf[63:0];
    end
  end

  otdv_div #(.DW(32), .Q(32)) u_hp (
    .clk_i, .en_i(en), .dvd_i(hp_dvd_q), .dvs_i(sgp_q),
    .quo_o(hp_raw), .ovf_o(hp_ovf)
  );

  assign tt70 = hp_raw | {32{hp_ovf}};

  // transfer speeds and burns
  logic [32:0]        vc1_q, vc2_q;
  logic [34:0]        vt1_q, vt2_q;
  logic [64:0]        pr1, pr2;
  logic signed [31:0] b1_q, b2_q;

  assign pr1 = 65'(vc1c) * 65'(sf1_68);
  assign pr2 = 65'(vc2c) * 65'(sf2_68);

  always_ff @(posedge clk_i) begin
    if (en) begin
      vc1_q <= vc1c;
      vc2_q <= vc2c;
      vt1_q <= pr1[64:30];
      vt2_q <= pr2[64:30];
      b1_q  <= sat32($signed({1'b0, vt1_q}) - $signed({3'b000, vc1_q}));
      b2_q  <= sat32($signed({3'b000, vc2_q}) - $signed({1'b0, vt2_q}));
    end
  end

  // output register
  logic signed [31:0] burn_one_q, burn_two_q, burn_sum_q;
  logic [31:0]        travel_time_q, axis_length_q;
  logic               bad_altitude_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bad_altitude_q <= bad70;
      if (bad70) begin
        burn_one_q    <= '0;
        burn_two_q    <= '0;
        burn_sum_q    <= '0;
        travel_time_q <= '0;
        axis_length_q <= '0;
      end else begin
        burn_one_q    <= b1_q;
        burn_two_q    <= b2_q;
        burn_sum_q    <= sat32({{4{b1_q[31]}}, b1_q} + {{4{b2_q[31]}}, b2_q});
        travel_time_q <= tt70;
        axis_length_q <= a70;
      end
    end
  end

  assign burn_one_o     = burn_one_q;
  assign burn_two_o     = burn_two_q;
  assign burn_sum_o     = burn_sum_q;
  assign travel_time_o  = travel_time_q;
  assign axis_length_o  = axis_length_q;
  assign bad_altitude_o = bad_altitude_q;

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_altitude_o |-> burn_one_o == 0 && burn_two_o == 0 &&
      burn_sum_o == 0 && travel_time_o == 0 && axis_length_o == 0)
    else $error("bad altitude beat carries nonzero results");

  a_axis_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_altitude_o |-> axis_length_o != 0)
    else $error("good beat with zero transfer axis");

  a_zero_mu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_altitude_o && sgp_q == 0 |->
      travel_time_o == 32'hFFFFFFFF && burn_sum_o == 0)
    else $error("zero sqrt(mu) did not saturate time");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for orbit_transfer_delta_v: random altitudes and register settings,
// streaming handshakes with random gaps, results checked in order against a built-in predictor.
// Depends on the orbit_transfer_delta_v RTL only.
`timescale 1ns / 100ps

class transfer_scoreboard;
  logic [31:0] radius_reg;
  logic [31:0] root_mu_reg;
  logic [191:0] pending_q[$];
  int unsigned fail_count;

  function new();
    radius_reg = 32'd6531212;
    root_mu_reg = 32'd41376022;
    fail_count = 0;
  endfunction

  function logic [63:0] int_root(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function logic [63:0] orbit_speed(logic [63:0] rad);
    logic [63:0] sq;
    logic [63:0] v;
    sq = int_root(rad << 30);
    if (sq == 0) return 64'h1_FFFF_FFFF;
    v = ({32'd0, root_mu_reg} << 20) / sq;
    return (v > 64'h1_FFFF_FFFF) ? 64'h1_FFFF_FFFF : v;
  endfunction

  function logic [63:0] gain_factor(logic [63:0] num, logic [63:0] den);
    logic [63:0] ratio;
    ratio = ((2 * num) << 30) / den;
    return int_root(ratio << 30);
  endfunction

  function logic [31:0] half_orbit_time(logic [63:0] a);
    logic [127:0] prod;
    logic [127:0] shifted;
    logic [63:0] num;
    if (root_mu_reg == 0) return 32'hFFFF_FFFF;
    num = a * int_root(a << 30);
    prod = {64'd0, num} * 128'd1686629713;
    shifted = prod >> 39;
    if (shifted[127:64] != 0 || shifted[63:0] >= ({32'd0, root_mu_reg} << 32))
      return 32'hFFFF_FFFF;
    return 32'(shifted[63:0] / {32'd0, root_mu_reg});
  endfunction

  function logic signed [63:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void note_input(logic signed [31:0] h1, logic signed [31:0] h2);
    logic [63:0] r1, r2, total, vc1, vc2, vt1, vt2;
    logic [127:0] m;
    logic signed [63:0] b1, b2, bs;
    if (h1 <= 0 || h2 <= 0) begin
      pending_q.push_back({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1});
      return;
    end
    r1 = {32'd0, h1} + radius_reg;
    r2 = {32'd0, h2} + radius_reg;
    total = r1 + r2;
    vc1 = orbit_speed(r1);
    vc2 = orbit_speed(r2);
    m = {64'd0, vc1} * gain_factor(r2, total);
    vt1 = m[63:0] >> 30;
    m = {64'd0, vc2} * gain_factor(r1, total);
    vt2 = m[63:0] >> 30;
    b1 = clip32($signed(vt1) - $signed(vc1));
    b2 = clip32($signed(vc2) - $signed(vt2));
    bs = clip32(b1 + b2);
    pending_q.push_back({b1[31:0], b2[31:0], bs[31:0], half_orbit_time(total >> 1),
                         total[32:1], 32'd0});
  endfunction

  function void check_result(logic [191:0] got);
    logic [191:0] want;
    if (pending_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result beat %h", got);
      return;
    end
    want = pending_q.pop_front();
    for (int i = 0; i < 6; i++) begin
      if (want[32*i +: 32] !== got[32*i +: 32]) begin
        fail_count++;
        if (fail_count <= 10)
          $display("field %0d: expected %h actual %h", 5 - i, want[32*i +: 32],
                   got[32*i +: 32]);
      end
    end
  endfunction
endclass

module testbench;
  localparam int unsigned N_RANDOM = 1800;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned PIPE_DEPTH = 71;
  localparam logic [2:0] ADDR_RADIUS = 3'd0;
  localparam logic [2:0] ADDR_ROOT_MU = 3'd4;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, bad_altitude_o;
  logic signed [31:0] start_altitude_i, target_altitude_i;
  logic signed [31:0] burn_one_o, burn_two_o, burn_sum_o;
  logic [31:0] travel_time_o, axis_length_o;

  transfer_scoreboard sb;
  bit hold_off;
  int unsigned idle_cycles = 0;

  orbit_transfer_delta_v uut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] pick_altitude();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(1, 16);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 15);
      default: return $urandom_range(1, 40000000);
    endcase
  endfunction

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_RADIUS) sb.radius_reg = data & 32'h7FFF_FFFF;
    else sb.root_mu_reg = data;
    @(posedge clk_i);
  endtask

  task automatic send_beat(input logic [31:0] h1, input logic [31:0] h2);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_altitude_i <= h1;
    target_altitude_i <= h2;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(h1, h2);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  // receiver side with random stalls and one long hold-off
  initial begin
    int unsigned n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      out_ready_i <= 1'b1;
      n = $urandom_range(0, 3) == 0 ? gap_len() : 0;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result({burn_one_o, burn_two_o, burn_sum_o, travel_time_o, axis_length_o,
                         31'd0, bad_altitude_o});
      if (n != 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [31:0] radii[4];
    logic [31:0] roots[4];
    sb = new();
    hold_off = 0;
    rst_ni = 1'b0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; start_altitude_i = 0; target_altitude_i = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers
    send_beat(32'd409600, 32'd36500000);
    send_beat(32'd36500000, 32'd409600);
    send_beat(0, 32'd1000);
    send_beat(32'd1000, 0);
    send_beat(32'h8000_0000, 32'd5);
    send_beat(32'd5, 32'hFFFF_FFFF);
    send_beat(32'd1, 32'd1);
    send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(32'd1, 32'h7FFF_FFFF);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555);
    send_beat(32'h5555_5555, 32'h2AAA_AAAA);
    drain();
    // zero radius: huge circular speeds; zero root mu
    reg_write(ADDR_RADIUS, 0);
    reg_write(ADDR_ROOT_MU, 32'hFFFF_FFFF);
    send_beat(32'd1, 32'd2);
    send_beat(32'd1, 32'h7FFF_FFFF);
    send_beat(32'h7FFF_FFFF, 32'd1);
    drain();
    reg_write(ADDR_ROOT_MU, 0);
    send_beat(32'd1, 32'd3);
    send_beat(32'd500000, 32'd700000);
    drain();
    reg_write(ADDR_RADIUS, 32'hFFFF_FFFF);
    reg_write(ADDR_ROOT_MU, 32'd1);
    send_beat(32'd1, 32'd1);
    send_beat(32'h7FFF_FFFF, 32'd10);
    drain();

    radii = '{32'd6531212, 32'h7FFF_FFFF, 32'd0, 32'd3500000};
    roots = '{32'd41376022, 32'd1, 32'hFFFF_FFFF, 32'd20000000};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 4) begin
        reg_write(ADDR_RADIUS, radii[ph]);
        reg_write(ADDR_ROOT_MU, roots[ph]);
      end else begin
        reg_write(ADDR_RADIUS, $urandom);
        reg_write(ADDR_ROOT_MU, $urandom);
      end
      if (ph == 1) hold_off = 1;
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        if ($urandom_range(0, 19) == 0) send_beat($urandom, $urandom);
        else send_beat(pick_altitude(), pick_altitude());
      end
      drain();
    end
    if (sb.fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/otdv_pkg.sv
rtl/otdv_delay.sv
rtl/otdv_sqrt.sv
rtl/otdv_div.sv
rtl/orbit_transfer_delta_v.sv
tb/sv/testbench.sv
